// ===== sv/cts_pkg.sv =====
package cts_pkg;

   // Default sample width (signed Q1.15 parts).
   localparam int SAMPLE_WIDTH_DEF = 16;

   // Result is signed Q3.30.
   localparam int OUT_W = 33;

   // Squared modulus brought to Q60, and the working width of the root search.
   localparam int Q60_W     = 62;
   localparam int ROOT_W    = 63;
   localparam int ISQ_STEPS = 32;

   // Phase unit: operands scaled to a 2^46 full scale, angles in 2^-32 turn.
   localparam int CORDIC_STEPS = 30;
   localparam int CORDIC_FS    = 47;
   localparam int XY_W         = 50;
   localparam int TURN_W       = 34;

   localparam logic signed [TURN_W-1:0] QUARTER_TURN = 34'sd1073741824;
   localparam logic signed [TURN_W-1:0] HALF_TURN    = 34'sd2147483648;

   // atan(2^-i) in units of 2^-32 turn.
   localparam logic [29:0] TURN_TABLE [CORDIC_STEPS] = '{
      30'd536870912, 30'd316933406, 30'd167458907, 30'd85004756, 30'd42667331,
      30'd21354465,  30'd10679838,  30'd5340245,   30'd2670163,  30'd1335087,
      30'd667544,    30'd333772,    30'd166886,    30'd83443,    30'd41722,
      30'd20861,     30'd10430,     30'd5215,      30'd2608,     30'd1304,
      30'd652,       30'd326,       30'd163,       30'd81,       30'd41,
      30'd20,        30'd10,        30'd5,         30'd3,        30'd1
   };

   // Stage counts of the datapath units.
   localparam int SQ_LAT   = 3;
   localparam int ISQ_LAT  = ISQ_STEPS + 1;
   localparam int COR_LAT  = CORDIC_STEPS + 2;
   localparam int PIPE_LAT = SQ_LAT + ISQ_LAT;

   typedef enum logic [2:0] {
      MODE_REAL    = 3'd0,
      MODE_MODULUS = 3'd1,
      MODE_SQUARED = 3'd2,
      MODE_IMAG    = 3'd3,
      MODE_PHASE   = 3'd4
   } view_mode_type;

endpackage

// ===== sv/cts_delay.sv =====
module cts_delay #(
   parameter int WIDTH = 8,
   parameter int DEPTH = 1
) (
   input  logic             clock,
   input  logic             en,
   input  logic [WIDTH-1:0] din,
   output logic [WIDTH-1:0] dout
);

   logic [WIDTH-1:0] tap_ff [DEPTH];

   always_ff @(posedge clock) begin
      if (en) begin
         tap_ff[0] <= din;
         for (int i = 1; i < DEPTH; i++) begin
            tap_ff[i] <= tap_ff[i-1];
         end
      end
   end

   assign dout = tap_ff[DEPTH-1];

endmodule

// ===== sv/cts_square.sv =====
module cts_square #(
   parameter int SAMPLE_WIDTH = cts_pkg::SAMPLE_WIDTH_DEF
) (
   input  logic                          clock,
   input  logic                          en,
   input  logic signed [SAMPLE_WIDTH-1:0] re,
   input  logic signed [SAMPLE_WIDTH-1:0] im,
   output logic [cts_pkg::Q60_W-1:0]     q60,
   output logic [cts_pkg::OUT_W-1:0]     sq_q30
);

   localparam int OUT_W  = cts_pkg::OUT_W;
   localparam int Q60_W  = cts_pkg::Q60_W;
   localparam int MAG_W  = 2 * SAMPLE_WIDTH;
   localparam int PROD_W = MAG_W - 1;
   localparam int F2     = 2 * (SAMPLE_WIDTH - 1);

   logic signed [MAG_W-1:0] re_full, im_full;
   logic [PROD_W-1:0] re_sq_in, re_sq_ff, im_sq_in, im_sq_ff;
   logic [MAG_W-1:0]  mag2_in, mag2_ff;
   logic [Q60_W-1:0]  q60_in, q60_ff;
   logic [OUT_W-1:0]  sq_in, sq_ff;

   // Stage 1: squares (non-negative, one bit narrower than the full product)
   always_comb begin
      re_full  = re * re;
      im_full  = im * im;
      re_sq_in = re_full[PROD_W-1:0];
      im_sq_in = im_full[PROD_W-1:0];
   end

   // Stage 2: exact sum
   assign mag2_in = MAG_W'(re_sq_ff) + MAG_W'(im_sq_ff);

   // Stage 3: bring to Q60 and Q30, round half up where bits drop
   if (F2 <= 60) begin : g_q60_shift
      assign q60_in = Q60_W'(mag2_ff) << (60 - F2);
   end else begin : g_q60_round
      logic [MAG_W:0] q60_sum;
      assign q60_sum = (MAG_W+1)'(mag2_ff) + ((MAG_W+1)'(1) << (F2 - 61));
      assign q60_in  = Q60_W'(q60_sum >> (F2 - 60));
   end

   if (F2 <= 30) begin : g_sq_shift
      assign sq_in = OUT_W'(mag2_ff) << (30 - F2);
   end else begin : g_sq_round
      logic [MAG_W:0] sq_sum;
      assign sq_sum = (MAG_W+1)'(mag2_ff) + ((MAG_W+1)'(1) << (F2 - 31));
      assign sq_in  = sq_sum[F2-30 +: OUT_W];
   end

   always_ff @(posedge clock) begin
      if (en) begin
         re_sq_ff <= re_sq_in;
         im_sq_ff <= im_sq_in;
         mag2_ff  <= mag2_in;
         q60_ff   <= q60_in;
         sq_ff    <= sq_in;
      end
   end

   assign q60    = q60_ff;
   assign sq_q30 = sq_ff;

endmodule

// ===== sv/cts_isqrt.sv =====
module cts_isqrt (
   input  logic                      clock,
   input  logic                      en,
   input  logic [cts_pkg::Q60_W-1:0] q60,
   output logic [cts_pkg::OUT_W-1:0] root
);

   localparam int OUT_W  = cts_pkg::OUT_W;
   localparam int Q60_W  = cts_pkg::Q60_W;
   localparam int ROOT_W = cts_pkg::ROOT_W;
   localparam int STEPS  = cts_pkg::ISQ_STEPS;

   logic [Q60_W-1:0]  rem_ff  [STEPS];
   logic [ROOT_W-1:0] part_ff [STEPS];
   logic [OUT_W-1:0]  root_in, root_ff;
   logic              round_up;

   // One result bit per stage, highest first
   for (genvar k = 0; k < STEPS; k++) begin : g_step
      localparam logic [ROOT_W-1:0] BIT = ROOT_W'(1) << (2 * (STEPS - 1 - k));
      logic [Q60_W-1:0]  rem_src, rem_in;
      logic [ROOT_W-1:0] part_src, part_in, trial;
      logic              fits;

      if (k == 0) begin : g_first
         assign rem_src  = q60;
         assign part_src = '0;
      end else begin : g_next
         assign rem_src  = rem_ff[k-1];
         assign part_src = part_ff[k-1];
      end

      always_comb begin
         trial = part_src + BIT;
         fits  = ROOT_W'(rem_src) >= trial;
         if (fits) begin
            rem_in  = rem_src - trial[Q60_W-1:0];
            part_in = (part_src >> 1) + BIT;
         end else begin
            rem_in  = rem_src;
            part_in = part_src >> 1;
         end
      end

      always_ff @(posedge clock) begin
         if (en) begin
            rem_ff[k]  <= rem_in;
            part_ff[k] <= part_in;
         end
      end
   end

   // Round to nearest: bump when the remainder exceeds the root
   always_comb begin
      round_up = ROOT_W'(rem_ff[STEPS-1]) > part_ff[STEPS-1];
      root_in  = OUT_W'(part_ff[STEPS-1]) + OUT_W'(round_up);
   end

   always_ff @(posedge clock) begin
      if (en) begin
         root_ff <= root_in;
      end
   end

   assign root = root_ff;

endmodule

// ===== sv/cts_cordic.sv =====
module cts_cordic #(
   parameter int SAMPLE_WIDTH = cts_pkg::SAMPLE_WIDTH_DEF
) (
   input  logic                           clock,
   input  logic                           en,
   input  logic signed [SAMPLE_WIDTH-1:0] re,
   input  logic signed [SAMPLE_WIDTH-1:0] im,
   output logic [cts_pkg::OUT_W-1:0]      phase
);

   localparam int OUT_W    = cts_pkg::OUT_W;
   localparam int XY_W     = cts_pkg::XY_W;
   localparam int TURN_W   = cts_pkg::TURN_W;
   localparam int STEPS    = cts_pkg::CORDIC_STEPS;
   localparam int SCALE_SH = cts_pkg::CORDIC_FS - SAMPLE_WIDTH;

   localparam logic signed [TURN_W-1:0] QT = cts_pkg::QUARTER_TURN;
   localparam logic [OUT_W-1:0] PH_POS_RE = OUT_W'(QT >>> 1);
   localparam logic [OUT_W-1:0] PH_NEG_RE = OUT_W'(QT);
   localparam logic [OUT_W-1:0] PH_POS_IM = OUT_W'(3 * (QT >>> 2));
   localparam logic [OUT_W-1:0] PH_NEG_IM = OUT_W'(QT >>> 2);

   typedef enum logic [2:0] {
      SP_NONE,
      SP_ZERO,
      SP_POS_RE,
      SP_NEG_RE,
      SP_POS_IM,
      SP_NEG_IM
   } special_type;

   logic signed [XY_W-1:0]   x_ff [STEPS+1];
   logic signed [XY_W-1:0]   y_ff [STEPS+1];
   logic signed [TURN_W-1:0] t_ff [STEPS+1];
   special_type              spec_ff [STEPS+1];

   logic signed [XY_W-1:0]   x_raw, y_raw, x0_in, y0_in;
   logic signed [TURN_W-1:0] t0_in;
   special_type              spec0_in;

   logic signed [TURN_W:0]   t_sum, t_sh;
   logic [OUT_W-1:0]         phase_in, phase_ff;

   // Stage 0: scale, fold the left half plane onto the right, flag axis cases
   always_comb begin
      x_raw = XY_W'(re) <<< SCALE_SH;
      y_raw = XY_W'(im) <<< SCALE_SH;
      x0_in = x_raw;
      y0_in = y_raw;
      t0_in = '0;
      if (x_raw < 0) begin
         if (y_raw >= 0) begin
            x0_in = y_raw;
            y0_in = -x_raw;
            t0_in = QT;
         end else begin
            x0_in = -y_raw;
            y0_in = x_raw;
            t0_in = -QT;
         end
      end

      if (re == 0 && im == 0) begin
         spec0_in = SP_ZERO;
      end else if (im == 0) begin
         spec0_in = (re > 0) ? SP_POS_RE : SP_NEG_RE;
      end else if (re == 0) begin
         spec0_in = (im > 0) ? SP_POS_IM : SP_NEG_IM;
      end else begin
         spec0_in = SP_NONE;
      end
   end

   always_ff @(posedge clock) begin
      if (en) begin
         x_ff[0]    <= x0_in;
         y_ff[0]    <= y0_in;
         t_ff[0]    <= t0_in;
         spec_ff[0] <= spec0_in;
      end
   end

   // Vectoring iterations: drive y toward zero, accumulate the turn count
   for (genvar g = 0; g < STEPS; g++) begin : g_step
      logic signed [XY_W-1:0]   dx, dy, x_in, y_in;
      logic signed [TURN_W-1:0] step, t_in;

      assign step = $signed(TURN_W'(cts_pkg::TURN_TABLE[g]));

      always_comb begin
         dx = y_ff[g] >>> g;
         dy = x_ff[g] >>> g;
         if (!y_ff[g][XY_W-1]) begin
            x_in = x_ff[g] + dx;
            y_in = y_ff[g] - dy;
            t_in = t_ff[g] + step;
         end else begin
            x_in = x_ff[g] - dx;
            y_in = y_ff[g] + dy;
            t_in = t_ff[g] - step;
         end
      end

      always_ff @(posedge clock) begin
         if (en) begin
            x_ff[g+1]    <= x_in;
            y_ff[g+1]    <= y_in;
            t_ff[g+1]    <= t_in;
            spec_ff[g+1] <= spec_ff[g];
         end
      end
   end

   // Final stage: add half a turn, round to Q30, clamp, apply axis values
   always_comb begin
      t_sum = (TURN_W+1)'(t_ff[STEPS]) + (TURN_W+1)'(cts_pkg::HALF_TURN)
              + (TURN_W+1)'(2);
      t_sh  = t_sum >>> 2;
      if (t_sh < 0) begin
         phase_in = '0;
      end else if (t_sh > (TURN_W+1)'(QT)) begin
         phase_in = OUT_W'(QT);
      end else begin
         phase_in = OUT_W'(t_sh);
      end

      case (spec_ff[STEPS])
         SP_ZERO:   phase_in = '0;
         SP_POS_RE: phase_in = PH_POS_RE;
         SP_NEG_RE: phase_in = PH_NEG_RE;
         SP_POS_IM: phase_in = PH_POS_IM;
         SP_NEG_IM: phase_in = PH_NEG_IM;
         default:   ;
      endcase
   end

   always_ff @(posedge clock) begin
      if (en) begin
         phase_ff <= phase_in;
      end
   end

   assign phase = phase_ff;

endmodule

// ===== sv/complex_to_scalar_view.sv =====
// Channel  Direction  Handshake                Payload
// req      in         req_valid / req_ready    req_real_part, req_imag_part (signed Q1.15)
// rsp      out        rsp_valid / rsp_ready    rsp_view_value (signed Q3.30)
// csr      in         csr_valid / csr_ready    csr_view_mode (3 bits)
//
// One transfer per cycle on req and rsp, each while its ready is high. The
// pipeline depth is set by the square-root pipeline (one root bit per stage,
// 32 stages plus rounding) behind three multiply and scaling stages.
// Reset is synchronous, with no clearing pass; req_ready is high afterward.
// A two-entry output buffer (result register plus skid register) drives a
// registered req_ready; req_ready falls only while both entries hold results.
module complex_to_scalar_view #(
   parameter int SAMPLE_WIDTH = cts_pkg::SAMPLE_WIDTH_DEF
) (
   input  logic                           clock,
   input  logic                           reset,

   input  logic                           req_valid,
   output logic                           req_ready,
   input  logic signed [SAMPLE_WIDTH-1:0] req_real_part,
   input  logic signed [SAMPLE_WIDTH-1:0] req_imag_part,

   output logic                           rsp_valid,
   input  logic                           rsp_ready,
   output logic signed [cts_pkg::OUT_W-1:0] rsp_view_value,

   input  logic                           csr_valid,
   output logic                           csr_ready,
   input  logic [2:0]                     csr_view_mode
);

   localparam int OUT_W    = cts_pkg::OUT_W;
   localparam int Q60_W    = cts_pkg::Q60_W;
   localparam int PIPE_LAT = cts_pkg::PIPE_LAT;

   // Mode register
   logic [2:0] view_mode_ff, view_mode_in;

   // Pipeline control: one global advance, valid bits ride alongside the data
   logic                en;
   logic [PIPE_LAT-1:0] valid_ff, valid_in;

   // Output buffer
   logic             out_valid_ff, out_valid_in, skid_valid_ff, skid_valid_in;
   logic [OUT_W-1:0] out_data_ff, out_data_in, skid_data_ff, skid_data_in;
   logic             push, pop;
   logic [OUT_W-1:0] result;

   // Datapath
   logic signed [OUT_W-1:0] re_q30, im_q30;
   logic [OUT_W-1:0]        direct_val, direct_out;
   logic [2:0]              mode_out;
   logic [Q60_W-1:0]        q60;
   logic [OUT_W-1:0]        sq_q30, sq_out, root_out, phase_raw, phase_out;

   // Advance whenever the skid register is free; at worst the advancing item
   // lands there.
   assign en        = !skid_valid_ff;
   assign req_ready = en;
   assign csr_ready = 1'b1;

   assign view_mode_in = csr_valid ? csr_view_mode : view_mode_ff;
   assign valid_in     = en ? {valid_ff[PIPE_LAT-2:0], req_valid} : valid_ff;

   // Real and imaginary parts straight to Q30 (round half up when too fine)
   if (SAMPLE_WIDTH <= 31) begin : g_direct_shift
      assign re_q30 = OUT_W'(req_real_part) <<< (31 - SAMPLE_WIDTH);
      assign im_q30 = OUT_W'(req_imag_part) <<< (31 - SAMPLE_WIDTH);
   end else begin : g_direct_round
      assign re_q30 = (OUT_W'(req_real_part) + OUT_W'(1)) >>> 1;
      assign im_q30 = (OUT_W'(req_imag_part) + OUT_W'(1)) >>> 1;
   end

   // Imaginary mode takes the imaginary part; every other code falls back to
   // the real part here and is overridden at the end if it means more.
   assign direct_val = (view_mode_ff == cts_pkg::MODE_IMAG) ? im_q30 : re_q30;

   cts_delay #(.WIDTH(3), .DEPTH(PIPE_LAT)) u_mode_dly (
      .clock (clock),
      .en    (en),
      .din   (view_mode_ff),
      .dout  (mode_out)
   );

   cts_delay #(.WIDTH(OUT_W), .DEPTH(PIPE_LAT)) u_direct_dly (
      .clock (clock),
      .en    (en),
      .din   (direct_val),
      .dout  (direct_out)
   );

   cts_square #(.SAMPLE_WIDTH(SAMPLE_WIDTH)) u_square (
      .clock  (clock),
      .en     (en),
      .re     (req_real_part),
      .im     (req_imag_part),
      .q60    (q60),
      .sq_q30 (sq_q30)
   );

   cts_delay #(.WIDTH(OUT_W), .DEPTH(PIPE_LAT - cts_pkg::SQ_LAT)) u_sq_dly (
      .clock (clock),
      .en    (en),
      .din   (sq_q30),
      .dout  (sq_out)
   );

   cts_isqrt u_isqrt (
      .clock (clock),
      .en    (en),
      .q60   (q60),
      .root  (root_out)
   );

   cts_cordic #(.SAMPLE_WIDTH(SAMPLE_WIDTH)) u_cordic (
      .clock (clock),
      .en    (en),
      .re    (req_real_part),
      .im    (req_imag_part),
      .phase (phase_raw)
   );

   cts_delay #(.WIDTH(OUT_W), .DEPTH(PIPE_LAT - cts_pkg::COR_LAT)) u_phase_dly (
      .clock (clock),
      .en    (en),
      .din   (phase_raw),
      .dout  (phase_out)
   );

   // Pick the view that the item was accepted under
   always_comb begin
      case (mode_out)
         cts_pkg::MODE_MODULUS: result = root_out;
         cts_pkg::MODE_SQUARED: result = sq_out;
         cts_pkg::MODE_PHASE:   result = phase_out;
         default:               result = direct_out;
      endcase
   end

   // Output buffer: the last stage drains on every advance
   assign push = en && valid_ff[PIPE_LAT-1];
   assign pop  = out_valid_ff && rsp_ready;

   always_comb begin
      out_valid_in  = out_valid_ff;
      out_data_in   = out_data_ff;
      skid_valid_in = skid_valid_ff;
      skid_data_in  = skid_data_ff;
      if (skid_valid_ff) begin
         // Pipeline is held; refill the result register from the skid
         if (pop) begin
            out_data_in   = skid_data_ff;
            skid_valid_in = 1'b0;
         end
      end else if (push) begin
         if (!out_valid_ff || pop) begin
            out_data_in  = result;
            out_valid_in = 1'b1;
         end else begin
            skid_data_in  = result;
            skid_valid_in = 1'b1;
         end
      end else if (pop) begin
         out_valid_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         view_mode_ff  <= cts_pkg::MODE_REAL;
         valid_ff      <= '0;
         out_valid_ff  <= 1'b0;
         skid_valid_ff <= 1'b0;
      end else begin
         view_mode_ff  <= view_mode_in;
         valid_ff      <= valid_in;
         out_valid_ff  <= out_valid_in;
         skid_valid_ff <= skid_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      out_data_ff  <= out_data_in;
      skid_data_ff <= skid_data_in;
   end

   assign rsp_valid      = out_valid_ff;
   assign rsp_view_value = $signed(out_data_ff);

endmodule

// ===== sv/cts_checker.sv =====
module cts_checker (
   input logic        clock,
   input logic        reset,
   input logic        req_ready,
   input logic        rsp_valid,
   input logic        rsp_ready,
   input logic [32:0] rsp_view_value
);

   // Reset empties the output buffer and opens the input
   a_reset_state: assert property (@(posedge clock)
      reset |=> req_ready && !rsp_valid)
      else $error("buffer not empty after reset");

   // The skid entry is only ever filled behind a waiting result
   a_empty_ready: assert property (@(posedge clock) disable iff (reset)
      !rsp_valid |-> req_ready)
      else $error("input blocked with no result pending");

   // A full buffer stays full until a result is taken
   a_full_holds: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_ready && !req_ready |=> !req_ready)
      else $error("input reopened without a drain");

   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_ready |=> rsp_valid && $stable(rsp_view_value))
      else $error("stalled result changed");

   // Every view lies in [-1.0, 2.0]; the check covers the lower bound
   a_range: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> !rsp_view_value[32] || (rsp_view_value[31] && rsp_view_value[30]))
      else $error("result out of range");

endmodule

bind complex_to_scalar_view cts_checker u_cts_checker (.*);

// ===== tb/tb.sv =====
`timescale 1ns / 100ps

// Streams complex samples through complex_to_scalar_view under every view
// mode and checks each scalar against a typed-in answer or a bit-accurate local predictor.
module tb;

   localparam int SW          = cts_pkg::SAMPLE_WIDTH_DEF;
   localparam int OW          = cts_pkg::OUT_W;
   localparam int ROTATIONS   = 30;
   localparam int CYCLE_LIMIT = 900000;
   localparam int PRINT_CAP   = 100;
   localparam int PHASES      = 15;

   // modes 5..7 are not decoded by the block and fall back to the real part
   localparam logic [2:0] MODE_SPARE_5 = 3'd5;
   localparam logic [2:0] MODE_SPARE_6 = 3'd6;
   localparam logic [2:0] MODE_SPARE_7 = 3'd7;

   // angle units: 2^-32 turn
   localparam longint QTURN = 64'sd1073741824;
   localparam longint HTURN = 64'sd2147483648;

   typedef struct {
      logic [2:0]             mode;
      logic signed [SW-1:0]   re;
      logic signed [SW-1:0]   im;
      bit                     known;
      logic signed [OW-1:0]   value;
   } stim_row_type;

   logic                 clock;
   logic                 reset;
   logic                 req_valid;
   logic                 req_ready;
   logic signed [SW-1:0] req_real_part;
   logic signed [SW-1:0] req_imag_part;
   logic                 rsp_valid;
   logic                 rsp_ready;
   logic signed [OW-1:0] rsp_view_value;
   logic                 csr_valid;
   logic                 csr_ready;
   logic [2:0]           csr_view_mode;

   // side band that travels with the req payload: typed-in answer, if any
   bit                   req_known;
   logic signed [OW-1:0] req_typed;

   // atan(2^-i) as a fraction of a turn, scaled by 2^32
   longint atan_turn [ROTATIONS] = '{
      536870912, 316933406, 167458907, 85004756, 42667331,
      21354465,  10679838,  5340245,   2670163,  1335087,
      667544,    333772,    166886,    83443,    41722,
      20861,     10430,     5215,      2608,     1304,
      652,       326,       163,       81,       41,
      20,        10,        5,         3,        1
   };

   logic [2:0] phase_modes [10] = '{
      cts_pkg::MODE_REAL, cts_pkg::MODE_MODULUS, cts_pkg::MODE_SQUARED,
      cts_pkg::MODE_IMAG, cts_pkg::MODE_PHASE, MODE_SPARE_5, MODE_SPARE_6,
      MODE_SPARE_7, cts_pkg::MODE_PHASE, cts_pkg::MODE_MODULUS
   };

   logic signed [OW-1:0] view_q [$];   // scalars still owed by the block
   stim_row_type         dir_rows [$];
   logic [2:0]           mode_now;     // mode as the block holds it
   logic [2:0]           mode_set;     // mode as the driver last wrote it
   int unsigned          err_count = 0;
   int unsigned          cycle_count = 0;
   int unsigned          quiet_left;

   complex_to_scalar_view dut (
      .clock          (clock),
      .reset          (reset),
      .req_valid      (req_valid),
      .req_ready      (req_ready),
      .req_real_part  (req_real_part),
      .req_imag_part  (req_imag_part),
      .rsp_valid      (rsp_valid),
      .rsp_ready      (rsp_ready),
      .rsp_view_value (rsp_view_value),
      .csr_valid      (csr_valid),
      .csr_ready      (csr_ready),
      .csr_view_mode  (csr_view_mode)
   );

   // ---------------------------------------------------------------- predictor

   // Integer square root, rounded to nearest (bit-by-bit restoring method).
   function automatic longint unsigned root_round(longint unsigned x);
      longint unsigned r;
      longint unsigned b;
      r = 0;
      b = 64'd1 << 62;
      while (b > x)
         b = b >> 2;
      while (b != 0) begin
         if (x >= r + b) begin
            x = x - (r + b);
            r = (r >> 1) + b;
         end else begin
            r = r >> 1;
         end
         b = b >> 2;
      end
      if (x > r)
         r = r + 1;
      return r;
   endfunction

   // Phase in [0,1] Q30 via vectoring CORDIC; axes and origin are exact.
   function automatic longint phase_turns(longint re, longint im);
      longint x;
      longint y;
      longint t;
      longint dx;
      longint dy;
      longint tmp;
      if (re == 0 && im == 0)
         return 0;
      if (im == 0)
         return (re > 0) ? (QTURN >>> 1) : QTURN;
      if (re == 0)
         return (im > 0) ? 3 * (QTURN >>> 2) : (QTURN >>> 2);
      // bring both parts up to a 2^46 full scale
      x = re * (64'sd1 <<< (47 - SW));
      y = im * (64'sd1 <<< (47 - SW));
      t = 0;
      // fold the left half plane onto the right one by a quarter turn
      if (x < 0) begin
         if (y >= 0) begin
            tmp = x; x = y; y = -tmp; t = QTURN;
         end else begin
            tmp = x; x = -y; y = tmp; t = -QTURN;
         end
      end
      for (int i = 0; i < ROTATIONS; i++) begin
         dx = y >>> i;
         dy = x >>> i;
         if (y >= 0) begin
            x = x + dx; y = y - dy; t = t + atan_turn[i];
         end else begin
            x = x - dx; y = y + dy; t = t - atan_turn[i];
         end
      end
      // add half a turn, round half up to Q30, clamp to [0, 1.0]
      t = (t + HTURN + 2) >>> 2;
      if (t < 0)
         t = 0;
      if (t > QTURN)
         t = QTURN;
      return t;
   endfunction

   function automatic logic signed [OW-1:0] predict_view(logic [2:0] mode,
         logic signed [SW-1:0] re, logic signed [SW-1:0] im);
      longint sre;
      longint sim;
      longint mag2;
      longint v;
      sre  = re;
      sim  = im;
      mag2 = sre * sre + sim * sim;
      case (mode)
         cts_pkg::MODE_MODULUS: v = longint'(root_round(longint'(mag2) << (62 - 2 * SW)));
         cts_pkg::MODE_SQUARED: v = mag2 << (32 - 2 * SW);
         cts_pkg::MODE_IMAG:    v = sim * (64'sd1 <<< (31 - SW));
         cts_pkg::MODE_PHASE:   v = phase_turns(sre, sim);
         default:               v = sre * (64'sd1 <<< (31 - SW));
      endcase
      return v[OW-1:0];
   endfunction

   // ---------------------------------------------------------------- helpers

   task automatic report_mismatch(input string what);
      err_count++;
      if (err_count <= PRINT_CAP)
         $display("[%0t] mismatch: %s", $time, what);
   endtask

   task automatic add_row(input logic [2:0] m, input int re, input int im,
         input bit known, input longint value);
      stim_row_type row;
      row.mode  = m;
      row.re    = re[SW-1:0];
      row.im    = im[SW-1:0];
      row.known = known;
      row.value = value[OW-1:0];
      dir_rows.push_back(row);
   endtask

   // Mostly short gaps, a few long ones.
   function automatic int unsigned pick_gap();
      int unsigned r;
      r = $urandom_range(0, 99);
      if (r < 50)
         return 0;
      if (r < 88)
         return $urandom_range(1, 3);
      if (r < 97)
         return $urandom_range(4, 10);
      return $urandom_range(20, 60);
   endfunction

   // Bias toward the corners of Q1.15, keep plenty of full-range values.
   function automatic logic signed [SW-1:0] pick_part();
      logic [31:0] r;
      r = $urandom();
      case ($urandom_range(0, 9))
         0:       return {1'b1, {(SW-1){1'b0}}};
         1:       return {1'b0, {(SW-1){1'b1}}};
         2:       return '0;
         3:       return SW'($signed($urandom_range(0, 15)) - 8);
         4:       return r[0] ? SW'(1) : -SW'(1);
         default: return r[SW-1:0];
      endcase
   endfunction

   // Called just after a rising edge. Hold the transfer until it is taken,
   // then idle for the given gap. With no gap, req_valid stays high.
   task automatic send_sample(input logic signed [SW-1:0] re,
         input logic signed [SW-1:0] im, input bit known,
         input logic signed [OW-1:0] value, input int unsigned gap);
      req_valid     <= 1'b1;
      req_real_part <= re;
      req_imag_part <= im;
      req_known     <= known;
      req_typed     <= value;
      do @(posedge clock); while (!req_ready);
      if (gap > 0) begin
         req_valid <= 1'b0;
         repeat (gap) @(posedge clock);
      end
   endtask

   // Drop req_valid and wait until every owed scalar has come back. Sample
   // the queue at the falling edge so the monitor's push or pop has settled.
   task automatic drain_views();
      req_valid <= 1'b0;
      @(negedge clock);
      while (view_q.size() != 0)
         @(negedge clock);
      @(posedge clock);
   endtask

   task automatic write_mode(input logic [2:0] m);
      csr_valid     <= 1'b1;
      csr_view_mode <= m;
      do @(posedge clock); while (!csr_ready);
      csr_valid <= 1'b0;
      mode_set = m;
   endtask

   // ---------------------------------------------------------------- clock / reset

   initial begin
      clock = 1'b0;
      forever #5 clock = ~clock;
   end

   initial begin
      reset <= 1'b1;
      repeat (7) @(posedge clock);
      reset <= 1'b0;
   end

   // ---------------------------------------------------------------- result side stalls

   // Alternate ready runs and stalls; long runs give stall-free stretches.
   initial begin : rsp_ready_gen
      int unsigned run;
      int unsigned stall;
      rsp_ready <= 1'b0;
      @(posedge clock);
      while (reset)
         @(posedge clock);
      forever begin
         run = ($urandom_range(0, 9) == 0) ? $urandom_range(40, 150)
                                           : $urandom_range(1, 6);
         rsp_ready <= 1'b1;
         repeat (run) @(posedge clock);
         stall = pick_gap();
         if (stall > 0) begin
            rsp_ready <= 1'b0;
            repeat (stall) @(posedge clock);
         end
      end
   end

   // ---------------------------------------------------------------- monitor

   // Track the mode, queue one expected scalar per req transfer, and match
   // each rsp transfer against the oldest one.
   always @(posedge clock) begin : view_monitor
      logic signed [OW-1:0] want;
      if (reset) begin
         mode_now = cts_pkg::MODE_REAL;
      end else begin
         if (csr_valid && csr_ready)
            mode_now = csr_view_mode;
         if (req_valid && req_ready)
            view_q.push_back(req_known ? req_typed
                             : predict_view(mode_now, req_real_part, req_imag_part));
         if (rsp_valid && rsp_ready) begin
            if (view_q.size() == 0) begin
               report_mismatch($sformatf("unexpected result %h", rsp_view_value));
            end else begin
               want = view_q.pop_front();
               if (rsp_view_value !== want)
                  report_mismatch($sformatf("view_value got %h want %h",
                                            rsp_view_value, want));
            end
         end
      end
   end

   // Hard stop if the block hangs.
   always @(posedge clock) begin
      cycle_count <= cycle_count + 1;
      if (cycle_count >= CYCLE_LIMIT) begin
         $display("Testbench completed WITH ERRORS");
         $finish;
      end
   end

   // ---------------------------------------------------------------- stimulus

   initial begin : stimulus
      int unsigned n_items;
      int unsigned gap;
      logic [2:0]  m;
      req_valid     <= 1'b0;
      req_real_part <= '0;
      req_imag_part <= '0;
      req_known     <= 1'b0;
      req_typed     <= '0;
      csr_valid     <= 1'b0;
      csr_view_mode <= cts_pkg::MODE_REAL;
      quiet_left  = 0;
      mode_set    = cts_pkg::MODE_REAL;

      // Directed rows. The first ones run on the reset mode, no write.
      add_row(cts_pkg::MODE_REAL, 0, 0, 1, 0);
      add_row(cts_pkg::MODE_REAL, 32767, -32768, 1, 1073709056);
      add_row(cts_pkg::MODE_REAL, -32768, 5, 1, -1073741824);
      add_row(cts_pkg::MODE_IMAG, 5, -32768, 1, -1073741824);
      add_row(cts_pkg::MODE_IMAG, 0, 32767, 1, 1073709056);
      // squared modulus peaks at 2.0 with both parts at -1
      add_row(cts_pkg::MODE_SQUARED, -32768, -32768, 1, 64'sd2147483648);
      add_row(cts_pkg::MODE_SQUARED, 0, 0, 1, 0);
      add_row(cts_pkg::MODE_SQUARED, 32767, 32767, 1, 2147352578);
      add_row(cts_pkg::MODE_MODULUS, -32768, 0, 1, 1073741824);
      add_row(cts_pkg::MODE_MODULUS, 0, 0, 1, 0);
      add_row(cts_pkg::MODE_MODULUS, 3, 4, 1, 163840);
      add_row(cts_pkg::MODE_MODULUS, -32768, -32768, 0, 0);
      // phase: origin, the four axes, then a corner and points just off the axes
      add_row(cts_pkg::MODE_PHASE, 0, 0, 1, 0);
      add_row(cts_pkg::MODE_PHASE, 100, 0, 1, 536870912);
      add_row(cts_pkg::MODE_PHASE, -100, 0, 1, 1073741824);
      add_row(cts_pkg::MODE_PHASE, 0, 100, 1, 805306368);
      add_row(cts_pkg::MODE_PHASE, 0, -100, 1, 268435456);
      add_row(cts_pkg::MODE_PHASE, -32768, -32768, 0, 0);
      add_row(cts_pkg::MODE_PHASE, -32768, 1, 0, 0);
      add_row(cts_pkg::MODE_PHASE, 32767, -1, 0, 0);
      add_row(cts_pkg::MODE_PHASE, -1, -32768, 0, 0);
      // unlisted modes fall back to the real part
      add_row(MODE_SPARE_5, 1234, -1, 1, 40435712);
      add_row(MODE_SPARE_6, 777, 32767, 0, 0);
      add_row(MODE_SPARE_7, -32768, 32767, 1, -1073741824);

      @(posedge clock);
      while (reset)
         @(posedge clock);

      foreach (dir_rows[i]) begin
         if (dir_rows[i].mode != mode_set) begin
            drain_views();
            write_mode(dir_rows[i].mode);
         end
         send_sample(dir_rows[i].re, dir_rows[i].im, dir_rows[i].known,
                     dir_rows[i].value, pick_gap());
      end

      // Random phases: fixed walk over all modes first, then random modes.
      for (int p = 0; p < PHASES; p++) begin
         m = (p < 10) ? phase_modes[p] : 3'($urandom_range(0, 7));
         drain_views();
         write_mode(m);
         n_items = $urandom_range(90, 130);
         for (int k = 0; k < n_items; k++) begin
            if (quiet_left > 0) begin
               gap = 0;
               quiet_left--;
            end else if ($urandom_range(0, 39) == 0) begin
               gap = 0;
               quiet_left = $urandom_range(20, 80);
            end else begin
               gap = pick_gap();
            end
            send_sample(pick_part(), pick_part(), 1'b0, '0, gap);
         end
      end

      // Let the last scalars out, then watch for strays.
      drain_views();
      repeat (2 * cts_pkg::PIPE_LAT) @(posedge clock);
      if (err_count == 0)
         $display("Testbench completed without errors");
      else
         $display("Testbench completed WITH ERRORS");
      $finish;
   end

endmodule

// ===== files.f =====
sv/cts_pkg.sv
sv/cts_delay.sv
sv/cts_square.sv
sv/cts_isqrt.sv
sv/cts_cordic.sv
sv/complex_to_scalar_view.sv
sv/cts_checker.sv
tb/tb.sv
